@@ hdl/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Used by lr_cfg, lr_step and line_rasterizer_top; depends on nothing else.
package lr_pkg;

	localparam int COORD_W  = 6;
	localparam int STRIDE_W = 13;
	localparam int OFFSET_W = 18;
	localparam int COLOR_W  = 32;
	localparam int ERR_W    = 9;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd256;

	// register index is the word address, paddr[2]
	localparam logic REG_ROW_STRIDE = 1'b0;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] draw_color;
	} line_req_t;

	typedef struct packed {
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
		logic [OFFSET_W-1:0] pixel_offset;
		logic [COLOR_W-1:0]  pixel_color;
		logic                last_pixel;
	} pixel_res_t;

	// direction control for the step unit
	typedef struct packed {
		logic x_major;
		logic neg_x;
		logic neg_y;
	} step_ctl_t;

endpackage

@@ hdl/lr_cfg.sv @@
// APB register block holding row_stride.
// Depends on lr_pkg.
module lr_cfg
	import lr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output logic [STRIDE_W-1:0] row_stride
);

	logic [STRIDE_W-1:0] stride_q;
	logic                reg_idx;

	assign reg_idx = paddr[ADDR_W-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_ROW_STRIDE) begin
			stride_q <= pwdata[STRIDE_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROW_STRIDE: prdata = {{(DATA_W-STRIDE_W){1'b0}}, stride_q};
			default:        prdata = '0;
		endcase
	end

	assign row_stride = stride_q;

endmodule

@@ hdl/lr_step.sv @@
// Combinational step unit: one Bresenham step of error term, coordinates and byte offset.
// Depends on lr_pkg.
module lr_step
	import lr_pkg::*;
#(
	parameter int BYTES_PER_PIXEL = 4
) (
	input  step_ctl_t                 ctl,
	input  logic [COORD_W-1:0]        x,
	input  logic [COORD_W-1:0]        y,
	input  logic signed [ERR_W-1:0]   err,
	input  logic signed [ERR_W-1:0]   major2,
	input  logic signed [ERR_W-1:0]   minor2,
	input  logic [OFFSET_W-1:0]       offset,
	input  logic [STRIDE_W-1:0]       row_stride,
	output logic [COORD_W-1:0]        x_next,
	output logic [COORD_W-1:0]        y_next,
	output logic signed [ERR_W-1:0]   err_next,
	output logic [OFFSET_W-1:0]       offset_next
);

	localparam logic [OFFSET_W-1:0] BPP_OFF = OFFSET_W'(BYTES_PER_PIXEL);

	logic signed [ERR_W-1:0] err_sub;
	logic                    minor_step;
	logic                    step_x;
	logic                    step_y;
	logic [OFFSET_W-1:0]     stride_off;
	logic [OFFSET_W-1:0]     off_x;
	logic [OFFSET_W-1:0]     off_y;

	assign err_sub    = err - minor2;
	assign minor_step = err_sub < 0;
	assign err_next   = minor_step ? err_sub + major2 : err_sub;

	assign step_x = ctl.x_major | minor_step;
	assign step_y = !ctl.x_major | minor_step;

	assign x_next = step_x ? (ctl.neg_x ? x - 1'b1 : x + 1'b1) : x;
	assign y_next = step_y ? (ctl.neg_y ? y - 1'b1 : y + 1'b1) : y;

	// offset tracks y*stride + x*bpp modulo the offset width
	assign stride_off = OFFSET_W'(row_stride);
	assign off_x = step_x ? (ctl.neg_x ? OFFSET_W'(0) - BPP_OFF : BPP_OFF) : '0;
	assign off_y = step_y ? (ctl.neg_y ? OFFSET_W'(0) - stride_off : stride_off) : '0;
	assign offset_next = offset + off_x + off_y;

endmodule

@@ hdl/line_rasterizer_top.sv @@
// Line rasterizer top: sequencer, line registers, step unit and register block.
// First pixel: the request is registered in the idle state, the setup state registers the
// step terms and the first run-state step registers the result; one pixel per cycle after.
// busy covers setup plus one step-unit pass per pixel, so a new line is taken after the last.
// The receiver cannot stall; results are strobed for one cycle each.
// Reset: arst_n clears the sequencer and the strobe and sets row_stride to 256.
module line_rasterizer_top
	import lr_pkg::*;
#(
	parameter int BYTES_PER_PIXEL = 4,
	parameter int COORD_MAX       = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  line_req_t         request,
	output logic              busy,
	output logic              strobe,
	output pixel_res_t        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [COORD_W-1:0] CMAX = COORD_W'(COORD_MAX);
	localparam logic [COLOR_W-1:0] COLOR_MASK =
		{COLOR_W{1'b1}} >> (COLOR_W - 8 * BYTES_PER_PIXEL);

	typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN} state_t;

	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
		return (v > CMAX) ? CMAX : v;
	endfunction

	state_t                  state_q;
	logic [COORD_W-1:0]      x_q, y_q, ex_q, ey_q;
	logic [COLOR_W-1:0]      color_q;
	logic signed [ERR_W-1:0] err_q, major2_q, minor2_q;
	logic [OFFSET_W-1:0]     offset_q;
	step_ctl_t               ctl_q;
	logic                    strobe_q;
	pixel_res_t              result_q;

	logic [STRIDE_W-1:0]     row_stride;
	logic [COORD_W-1:0]      dx, dy, major_d, minor_d;
	step_ctl_t               ctl_setup;
	logic [COORD_W+STRIDE_W-1:0] row_base;
	logic [OFFSET_W-1:0]     x_bytes;
	logic                    at_end;

	logic [COORD_W-1:0]      x_next, y_next;
	logic signed [ERR_W-1:0] err_next;
	logic [OFFSET_W-1:0]     offset_next;

	lr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.row_stride (row_stride)
	);

	lr_step #(
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL)
	) u_step (
		.ctl         (ctl_q),
		.x           (x_q),
		.y           (y_q),
		.err         (err_q),
		.major2      (major2_q),
		.minor2      (minor2_q),
		.offset      (offset_q),
		.row_stride  (row_stride),
		.x_next      (x_next),
		.y_next      (y_next),
		.err_next    (err_next),
		.offset_next (offset_next)
	);

	// line setup: deltas, directions, starting offset
	always_comb begin
		dx = (ex_q >= x_q) ? ex_q - x_q : x_q - ex_q;
		dy = (ey_q >= y_q) ? ey_q - y_q : y_q - ey_q;
		ctl_setup.x_major = dx > dy;
		ctl_setup.neg_x   = ex_q < x_q;
		ctl_setup.neg_y   = ey_q < y_q;
		major_d = ctl_setup.x_major ? dx : dy;
		minor_d = ctl_setup.x_major ? dy : dx;
		row_base = {{STRIDE_W{1'b0}}, y_q} * {{COORD_W{1'b0}}, row_stride};
		x_bytes  = OFFSET_W'(x_q) * OFFSET_W'(BYTES_PER_PIXEL);
	end

	assign at_end = ctl_q.x_major ? (x_q == ex_q) : (y_q == ey_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q     <= clamp(request.start_x);
						y_q     <= clamp(request.start_y);
						ex_q    <= clamp(request.end_x);
						ey_q    <= clamp(request.end_y);
						color_q <= request.draw_color & COLOR_MASK;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					ctl_q    <= ctl_setup;
					err_q    <= ERR_W'(major_d) - ERR_W'(1);
					major2_q <= ERR_W'({major_d, 1'b0});
					minor2_q <= ERR_W'({minor_d, 1'b0});
					offset_q <= OFFSET_W'(row_base) + x_bytes;
					state_q  <= S_RUN;
				end
				S_RUN: begin
					strobe_q              <= 1'b1;
					result_q.pixel_x      <= x_q;
					result_q.pixel_y      <= y_q;
					result_q.pixel_offset <= offset_q;
					result_q.pixel_color  <= color_q;
					result_q.last_pixel   <= at_end;
					if (at_end) begin
						state_q <= S_IDLE;
					end else begin
						x_q      <= x_next;
						y_q      <= y_next;
						err_q    <= err_next;
						offset_q <= offset_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = strobe_q;
	assign result = result_q;

	// a pixel only follows a busy cycle
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("pixel strobe without a line in progress");

	// the end point closes the line
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_pixel |-> !busy)
		else $error("busy still high after the last pixel");

	// a pixel that is not the end point leaves the line in progress
	a_more_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_pixel |-> busy)
		else $error("line ended without a last pixel");

	// an accepted request starts work at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

endmodule

@@ tb/sv/line_rasterizer_top_tb.sv @@
// Self-checking testbench for line_rasterizer_top: random and directed line requests,
// row_stride writes over APB, every pixel strobe checked against a local Bresenham tracer.
// Depends on lr_pkg and the line_rasterizer_top RTL only.
module line_rasterizer_top_tb;
	import lr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BPP        = 4;
	localparam int COORD_TOP  = 63;
	localparam int REG_UNUSED = 1;
	localparam logic [ADDR_W-1:0] ADDR_ROW_STRIDE = {REG_ROW_STRIDE, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNUSED     = ADDR_W'(REG_UNUSED * 4);
	localparam int RANDOM_PHASES   = 6;
	localparam int LINES_PER_PHASE = 57;

	class pixel_scoreboard;
		pixel_res_t          pixel_queue[$];
		logic [STRIDE_W-1:0] stride;
		int                  errors;
		int                  lines;
		int                  pixels;

		function new();
			stride = STRIDE_RESET;
			errors = 0;
			lines  = 0;
			pixels = 0;
		endfunction

		function void set_register(int index, logic [DATA_W-1:0] value);
			if (index == 0)
				stride = value[STRIDE_W-1:0];
		endfunction

		function void push_pixel(int x, int y, logic [COLOR_W-1:0] color, bit last);
			pixel_res_t p;
			longint unsigned off;
			off = longint'(y) * longint'(stride) + longint'(x) * BPP;
			p.pixel_x      = x[COORD_W-1:0];
			p.pixel_y      = y[COORD_W-1:0];
			p.pixel_offset = off[OFFSET_W-1:0];
			p.pixel_color  = color;
			p.last_pixel   = last;
			pixel_queue.push_back(p);
		endfunction

		// trace the line the way the block walks it: error starts at major-1
		function void trace_line(line_req_t r);
			int x, y, ex, ey, dx, dy, sx, sy, maj, mnr, err, k;
			bit x_major;
			logic [63:0] cmask;
			logic [COLOR_W-1:0] color;
			x  = (r.start_x > COORD_TOP) ? COORD_TOP : r.start_x;
			y  = (r.start_y > COORD_TOP) ? COORD_TOP : r.start_y;
			ex = (r.end_x > COORD_TOP) ? COORD_TOP : r.end_x;
			ey = (r.end_y > COORD_TOP) ? COORD_TOP : r.end_y;
			cmask = (64'd1 << (8 * BPP)) - 64'd1;
			color = r.draw_color & cmask[COLOR_W-1:0];
			dx = (ex > x) ? ex - x : x - ex;
			dy = (ey > y) ? ey - y : y - ey;
			sx = (ex < x) ? -1 : 1;
			sy = (ey < y) ? -1 : 1;
			x_major = dx > dy;
			maj = x_major ? dx : dy;
			mnr = x_major ? dy : dx;
			err = maj - 1;
			k = 0;
			while ((x_major ? (x != ex) : (y != ey)) && k < COORD_TOP) begin
				push_pixel(x, y, color, 1'b0);
				k++;
				if (x_major) x += sx; else y += sy;
				err -= 2 * mnr;
				if (err < 0) begin
					err += 2 * maj;
					if (x_major) y += sy; else x += sx;
				end
			end
			push_pixel(x, y, color, 1'b1);
			lines++;
		endfunction

		function bit compare_field(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_pixel(pixel_res_t got);
			pixel_res_t e;
			bit ok;
			if (pixel_queue.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d off=0x%0h",
					$time, got.pixel_x, got.pixel_y, got.pixel_offset);
				errors++;
				return;
			end
			e = pixel_queue.pop_front();
			ok = compare_field("pixel_x", e.pixel_x, got.pixel_x);
			ok &= compare_field("pixel_y", e.pixel_y, got.pixel_y);
			ok &= compare_field("pixel_offset", e.pixel_offset, got.pixel_offset);
			ok &= compare_field("pixel_color", e.pixel_color, got.pixel_color);
			ok &= compare_field("last_pixel", e.last_pixel, got.last_pixel);
			if (!ok)
				errors++;
			pixels++;
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	line_req_t         request = '0;
	logic              busy;
	logic              strobe;
	pixel_res_t        result;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	pixel_scoreboard sb;
	bit              gaps_on = 1'b1;
	int              strides_used = 1;

	line_rasterizer_top #(
		.BYTES_PER_PIXEL(BPP),
		.COORD_MAX      (COORD_TOP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.strobe (strobe),
		.result (result),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_pixel(result);
	end

	initial begin
		#1000000;
		$display("timeout with %0d pixels outstanding", sb.pixel_queue.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [COORD_W-1:0] clip(int v);
		return COORD_W'((v < 0) ? 0 : (v > COORD_TOP) ? COORD_TOP : v);
	endfunction

	function automatic line_req_t make_line(int x0, int y0, int x1, int y1,
		logic [COLOR_W-1:0] color);
		line_req_t r;
		r.start_x    = COORD_W'(x0);
		r.start_y    = COORD_W'(y0);
		r.end_x      = COORD_W'(x1);
		r.end_y      = COORD_W'(y1);
		r.draw_color = color;
		return r;
	endfunction

	function automatic line_req_t random_line();
		int kind, x0, y0, d;
		line_req_t r;
		kind = $urandom_range(0, 9);
		x0 = $urandom_range(0, COORD_TOP);
		y0 = $urandom_range(0, COORD_TOP);
		r = make_line(x0, y0, $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
			$urandom());
		if (kind == 4 || kind == 5) begin
			r.end_x = clip(x0 + $urandom_range(0, 12) - 6);
			r.end_y = clip(y0 + $urandom_range(0, 12) - 6);
		end else if (kind == 6) begin
			r.end_x = COORD_W'(x0);
			r.end_y = COORD_W'(y0);
		end else if (kind == 7) begin
			if ($urandom_range(0, 1)) r.end_x = COORD_W'(x0); else r.end_y = COORD_W'(y0);
		end else if (kind == 8) begin
			d = $urandom_range(0, 31);
			r.end_x = COORD_W'((x0 + d > COORD_TOP) ? x0 - d : x0 + d);
			r.end_y = COORD_W'((y0 + d > COORD_TOP) ? y0 - d : y0 + d);
		end else if (kind == 9) begin
			r.start_x = COORD_W'($urandom_range(0, 1) ? COORD_TOP : 0);
			r.start_y = COORD_W'($urandom_range(0, 1) ? COORD_TOP : 0);
			r.end_x   = COORD_W'($urandom_range(0, 1) ? COORD_TOP : 0);
			r.end_y   = COORD_W'($urandom_range(0, 1) ? COORD_TOP : 0);
		end
		return r;
	endfunction

	// hold start until the block takes the request, then at times drop it for a gap
	task automatic send_line(line_req_t r);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sb.trace_line(r);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pixel_queue.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(int'(addr >> 2), data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_stride(logic [STRIDE_W-1:0] value);
		logic [DATA_W-1:0] word;
		word = $urandom();
		word[STRIDE_W-1:0] = value;
		write_reg(ADDR_ROW_STRIDE, word);
		strides_used++;
	endtask

	initial begin
		logic [STRIDE_W-1:0] phase_stride[RANDOM_PHASES];
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single pixels, axes, diagonals, each octant, color extremes
		send_line(make_line(0, 0, 0, 0, 32'h0000_0000));
		send_line(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
		send_line(make_line(0, 0, 63, 0, 32'hA5A5_A5A5));
		send_line(make_line(63, 63, 0, 63, 32'h5A5A_5A5A));
		send_line(make_line(0, 0, 0, 63, 32'h1234_5678));
		send_line(make_line(63, 63, 63, 0, 32'h8765_4321));
		send_line(make_line(0, 0, 63, 63, 32'hFFFF_FFFF));
		send_line(make_line(63, 0, 0, 63, 32'h0000_0000));
		send_line(make_line(10, 10, 50, 20, 32'hDEAD_BEEF));
		send_line(make_line(50, 20, 10, 10, 32'hCAFE_F00D));
		send_line(make_line(10, 10, 20, 50, 32'h0F0F_0F0F));
		send_line(make_line(20, 50, 10, 10, 32'hF0F0_F0F0));
		send_line(make_line(5, 40, 60, 30, 32'h0000_00FF));
		send_line(make_line(30, 5, 25, 60, 32'hFF00_0000));
		send_line(make_line(0, 63, 63, 62, 32'h8000_0001));
		send_line(make_line(63, 1, 0, 0, 32'h7FFF_FFFE));
		send_line(make_line(31, 31, 32, 32, 32'h0101_0101));
		send_line(make_line(31, 31, 33, 32, 32'hFEFE_FEFE));

		// stride at 8191 wraps the offset past 18 bits on the lower rows
		wait_idle();
		set_stride(13'h1FFF);
		send_line(make_line(0, 63, 63, 63, 32'hFFFF_FFFF));
		send_line(make_line(63, 0, 63, 63, 32'h0000_0000));
		send_line(make_line(0, 0, 63, 63, 32'h3C3C_3C3C));

		// an out-of-range register must not disturb row_stride
		wait_idle();
		write_reg(ADDR_UNUSED, $urandom());
		send_line(make_line(63, 63, 0, 0, 32'hC3C3_C3C3));

		phase_stride[0] = 13'd0;
		phase_stride[1] = 13'd4096;
		phase_stride[2] = 13'd1;
		phase_stride[3] = STRIDE_W'($urandom_range(0, 4096));
		phase_stride[4] = STRIDE_W'($urandom_range(0, 8191));
		phase_stride[5] = 13'd4096;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			if (ph == 2)
				write_reg(ADDR_UNUSED, $urandom());
			set_stride(phase_stride[ph]);
			gaps_on = (ph != RANDOM_PHASES - 1);
			for (int i = 0; i < LINES_PER_PHASE; i++)
				send_line(random_line());
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d lines and %0d pixels over %0d row_stride settings",
			sb.lines, sb.pixels, strides_used);
		$display("including stride extremes, offset wrap and ignored register writes");
		if (sb.errors == 0 && sb.pixel_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d pixels never seen", sb.errors, sb.pixel_queue.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
